[rtl/gewma_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gewma_pkg;

	// fraction bits of the Q16.16 samples and of the Q1.16 weight
	localparam int FRAC_BITS = 16;
	localparam int ALPHA_BITS = FRAC_BITS + 1;
	localparam int MINP_BITS = 16;

	// weight of 1.0 and the reset defaults of the weight (0.5) and the warm-up length
	localparam logic [ALPHA_BITS-1:0] ONE_Q16 = ALPHA_BITS'(1) << FRAC_BITS;
	localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ONE_Q16 >> 1;
	localparam logic [MINP_BITS-1:0] MINP_RESET = '0;

	// configuration port
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS = ALPHA_BITS;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SMOOTHING_FACTOR = 1'b0,
		CFG_WARMUP_LEN       = 1'b1
	} cfg_index_t;

	// settings seen by the datapath
	typedef struct packed {
		logic [ALPHA_BITS-1:0] alpha;
		logic [MINP_BITS-1:0]  warmup_len;
	} cfg_t;

endpackage

`default_nettype wire

[rtl/gewma_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

// input row channel
interface gewma_sample_if #(
	parameter int SAMPLE_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          sample_valid;
	logic                          group_start;

	modport source (output valid, sample, sample_valid, group_start, input ready);
	modport sink (input valid, sample, sample_valid, group_start, output ready);
endinterface

// result channel
interface gewma_result_if #(
	parameter int SAMPLE_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] average;
	logic                          average_valid;

	modport source (output valid, average, average_valid, input ready);
	modport sink (input valid, average, average_valid, output ready);
endinterface

// configuration write channel
interface gewma_cfg_if;
	logic                                    valid;
	logic                                    ready;
	logic [gewma_pkg::CFG_INDEX_BITS-1:0]    index;
	logic [gewma_pkg::CFG_DATA_BITS-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/gewma_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module gewma_cfg_regs (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_en,
	input  wire logic [gewma_pkg::CFG_INDEX_BITS-1:0] wr_index,
	input  wire logic [gewma_pkg::CFG_DATA_BITS-1:0]  wr_data,
	output gewma_pkg::cfg_t                           cfg
);

	logic [gewma_pkg::ALPHA_BITS-1:0] alpha_q;
	logic [gewma_pkg::MINP_BITS-1:0]  minp_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= gewma_pkg::ALPHA_RESET;
			minp_q  <= gewma_pkg::MINP_RESET;
		end else if (wr_en) begin
			unique case (gewma_pkg::cfg_index_t'(wr_index))
				gewma_pkg::CFG_SMOOTHING_FACTOR: begin
					alpha_q <= wr_data;
				end
				gewma_pkg::CFG_WARMUP_LEN: begin
					minp_q <= wr_data[gewma_pkg::MINP_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// weights above 1.0 act as 1.0
	always_comb begin
		cfg.alpha      = (alpha_q > gewma_pkg::ONE_Q16) ? gewma_pkg::ONE_Q16 : alpha_q;
		cfg.warmup_len = minp_q;
	end

endmodule

`default_nettype wire

[rtl/gewma_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module gewma_core #(
	parameter int SAMPLE_BITS = 32,
	parameter int COUNT_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gewma_pkg::cfg_t               cfg,
	input  wire logic                          fire,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic                          sample_valid,
	input  wire logic                          group_start,
	output logic signed [SAMPLE_BITS-1:0]      average,
	output logic                               average_valid
);

	localparam int DIFF_BITS = SAMPLE_BITS + 1;
	localparam int PROD_BITS = DIFF_BITS + gewma_pkg::ALPHA_BITS + 1;
	localparam int CMP_BITS  = (COUNT_BITS > gewma_pkg::MINP_BITS) ?
	                           COUNT_BITS : gewma_pkg::MINP_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
		PROD_BITS'(1) << (gewma_pkg::FRAC_BITS - 1);

	logic signed [SAMPLE_BITS-1:0] avg_q;
	logic [COUNT_BITS-1:0]         cnt_q;
	logic                          warm_q;

	logic signed [SAMPLE_BITS-1:0] avg_cur;
	logic [COUNT_BITS-1:0]         cnt_cur;
	logic                          warm_cur;
	logic signed [DIFF_BITS-1:0]   diff;
	logic signed [PROD_BITS-1:0]   prod;
	logic signed [PROD_BITS-1:0]   step;
	logic signed [SAMPLE_BITS-1:0] avg_blend;
	logic signed [SAMPLE_BITS-1:0] avg_nxt;
	logic [COUNT_BITS-1:0]         cnt_nxt;
	logic                          warm_nxt;

	// a group start clears the state before the row is applied
	assign avg_cur  = group_start ? '0 : avg_q;
	assign cnt_cur  = group_start ? '0 : cnt_q;
	assign warm_cur = group_start ? 1'b0 : warm_q;

	// avg + round(alpha * (sample - avg) / 2^16), same as the two-weight blend
	always_comb begin
		diff      = DIFF_BITS'(sample) - DIFF_BITS'(avg_cur);
		prod      = $signed({1'b0, cfg.alpha}) * diff;
		step      = (prod + ROUND_HALF) >>> gewma_pkg::FRAC_BITS;
		avg_blend = avg_cur + step[SAMPLE_BITS-1:0];
	end

	// next state for this row
	always_comb begin
		avg_nxt  = avg_cur;
		cnt_nxt  = cnt_cur;
		warm_nxt = warm_cur;
		if (sample_valid) begin
			avg_nxt  = (cnt_cur == '0) ? sample : avg_blend;
			cnt_nxt  = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
			warm_nxt = warm_cur |
			           (CMP_BITS'(cnt_nxt) >= CMP_BITS'(cfg.warmup_len));
		end
	end

	// result of this row
	assign average       = warm_nxt ? avg_nxt : '0;
	assign average_valid = warm_nxt;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q  <= '0;
			cnt_q  <= '0;
			warm_q <= 1'b0;
		end else if (fire) begin
			avg_q  <= avg_nxt;
			cnt_q  <= cnt_nxt;
			warm_q <= warm_nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/grouped_ewma_skip_invalid.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  payload                                  transfer
// rows      in   sample, sample_valid, group_start        valid & ready
// results   out  average, average_valid                   valid & ready
// cfg       in   index, data (0 smoothing, 1 min periods) valid & ready
//
// one row per cycle sustained while results are taken; a row passes through the row
// register and then the result register before its result is offered on results
// the whole update (one multiply, add, shift) runs between the row register and
// the result register, so each row's update uses the state left by the row before it
// reset clears the state, the handshakes and loads the register defaults
// a stalled result holds the row register; rows are still taken while it is free

module grouped_ewma_skip_invalid #(
	parameter int SAMPLE_BITS = 32,
	parameter int COUNT_BITS  = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	gewma_cfg_if.sink     cfg,
	gewma_sample_if.sink  rows,
	gewma_result_if.source results
);

	gewma_pkg::cfg_t cfg_cur;

	logic                          vld_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic                          svld_s1;
	logic                          gs_s1;

	logic                          out_vld_q;
	logic signed [SAMPLE_BITS-1:0] out_avg_q;
	logic                          out_avgv_q;

	logic                          advance;
	logic signed [SAMPLE_BITS-1:0] avg_res;
	logic                          avgv_res;

	// configuration registers, always ready
	assign cfg.ready = 1'b1;

	gewma_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_cur)
	);

	// row register moves on when the result register is free or drained
	assign advance    = vld_s1 & (~out_vld_q | results.ready);
	assign rows.ready = ~vld_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rows.ready) begin
			vld_s1 <= rows.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rows.ready && rows.valid) begin
			smp_s1  <= rows.sample;
			svld_s1 <= rows.sample_valid;
			gs_s1   <= rows.group_start;
		end
	end

	// state update and result
	gewma_core #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_cur),
		.fire          (advance),
		.sample        (smp_s1),
		.sample_valid  (svld_s1),
		.group_start   (gs_s1),
		.average       (avg_res),
		.average_valid (avgv_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_avg_q  <= avg_res;
			out_avgv_q <= avgv_res;
		end
	end

	assign results.valid         = out_vld_q;
	assign results.average       = out_avg_q;
	assign results.average_valid = out_avgv_q;

endmodule

`default_nettype wire

[rtl/gewma_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module gewma_chk #(
	parameter int SAMPLE_BITS = 32
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [SAMPLE_BITS-1:0] out_average,
	input wire logic                   out_average_valid
);

	// a result without warm-up carries a zero average
	ast_nan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_average_valid) |-> (out_average == '0))
		else $error("average not zero on a result marked invalid");

	// rows are never held off while the result register is empty
	ast_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("rows stalled with empty result register");

	// a fresh result comes from a row taken ahead of it through the row register
	ast_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a matching row transfer");

	// a stalled result holds its payload
	ast_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(out_average) && $stable(out_average_valid)))
		else $error("result changed while stalled");

endmodule

bind grouped_ewma_skip_invalid gewma_chk #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_gewma_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (rows.valid),
	.in_ready          (rows.ready),
	.out_valid         (results.valid),
	.out_ready         (results.ready),
	.out_average       (results.average),
	.out_average_valid (results.average_valid)
);

`default_nettype wire
